// ===== hdl/psac_pkg.sv =====
// Package for the per-slot allocation counter table.
// Holds the sizes, function and status codes, word types and the control
// interface types shared by the controller, datapath, top level and checker.
package psac_pkg;

  localparam int SLOTS        = 8;
  // The ring depth must be a power of two; the ring index is a mask of the head.
  localparam int RING_ENTRIES = 4096;
  localparam int SLOT_IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [31:0] RING_MASK = 32'(RING_ENTRIES - 1);

  localparam logic [2:0] FN_REGISTER = 3'd0;
  localparam logic [2:0] FN_ALLOC    = 3'd1;
  localparam logic [2:0] FN_FREE     = 3'd2;
  localparam logic [2:0] FN_STATUS   = 3'd3;
  localparam logic [2:0] FN_SNAPSHOT = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_SLOT  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot;
    logic [31:0] size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_record;
    logic [2:0]  slot_out;
    logic [31:0] live_count;
    logic [63:0] live_byte_total;
    logic [63:0] alloc_count;
    logic [63:0] free_count;
    logic [63:0] alloc_byte_total;
    logic [63:0] free_byte_total;
    logic [31:0] ring_position;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic        registered;
    logic [31:0] live_count;
    logic [63:0] live_octets;
    logic [63:0] alloc_count;
    logic [63:0] free_count;
    logic [63:0] alloc_bytes;
    logic [63:0] free_bytes;
  } slot_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic rec_emit;
    logic reply_emit;
    logic idx_clr;
    logic idx_inc;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] in_func;
    logic       ring_en;
    logic       cur_registered;
    logic       idx_last;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== hdl/psac_ctrl.sv =====
// Controller of the per-slot allocation counter table.
// Sequences request execution and the snapshot walk; uses psac_pkg.
module psac_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  psac_pkg::dp_sts_t  sts,
  output psac_pkg::ctl_cmd_t cmd
);
  import psac_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (sts.in_func)
            FN_REGISTER, FN_ALLOC, FN_FREE, FN_STATUS: state_nxt = S_EXEC;
            FN_SNAPSHOT: state_nxt = sts.ring_en ? S_WALK : S_REPLY;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_WALK: begin
        if ((!sts.cur_registered || sts.out_free) && sts.idx_last) state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load_req   = accept;
    cmd.idx_clr    = accept;
    case (state_r)
      S_EXEC:  cmd.exec = sts.out_free;
      S_WALK: begin
        // Unregistered slots are skipped without producing a word.
        cmd.rec_emit = sts.cur_registered && sts.out_free;
        cmd.idx_inc  = !sts.cur_registered || sts.out_free;
      end
      S_REPLY: cmd.reply_emit = sts.out_free;
      default: cmd.exec = 1'b0;
    endcase
  end

endmodule

// ===== hdl/psac_dp.sv =====
// Datapath of the per-slot allocation counter table.
// Holds the slot counter table, ring head, request and output registers;
// uses psac_pkg.
module psac_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  psac_pkg::in_word_t in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output psac_pkg::out_word_t out_data,
  input  psac_pkg::ctl_cmd_t cmd,
  output psac_pkg::dp_sts_t  sts
);
  import psac_pkg::*;

  slot_entry_t           tbl_r [SLOTS];
  in_word_t              req_r;
  logic                  ring_en_r;
  logic [31:0]           head_r;
  logic [31:0]           head_nxt;
  logic [SLOT_IDX_W-1:0] idx_r;
  logic [SLOT_IDX_W-1:0] idx_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_word_t             out_data_r;
  out_word_t             out_data_nxt;

  logic [SLOT_IDX_W-1:0] rd_idx;
  slot_entry_t           cur;
  slot_entry_t           wr_entry;
  logic                  wr_en;
  logic                  slot_bad;
  logic [63:0]           size64;
  out_word_t             exec_word;
  out_word_t             rec_word;
  out_word_t             reply_word;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The table has one read address: the walk index during a snapshot,
  // otherwise the request's slot.
  assign rd_idx   = (req_r.func == FN_SNAPSHOT) ? idx_r : req_r.slot[SLOT_IDX_W-1:0];
  assign cur      = tbl_r[rd_idx];
  assign slot_bad = (req_r.slot >= 8'(SLOTS));
  assign size64   = {32'd0, req_r.size};

  assign sts.in_func        = in_data.func;
  assign sts.ring_en        = ring_en_r;
  assign sts.cur_registered = cur.registered;
  assign sts.idx_last       = (idx_r == SLOT_IDX_W'(SLOTS - 1));
  assign sts.out_free       = !out_valid_r || out_ready;

  always_comb begin
    wr_en          = 1'b0;
    wr_entry       = cur;
    exec_word      = '0;
    exec_word.last = 1'b1;
    case (req_r.func)
      FN_REGISTER: begin
        wr_entry            = '0;
        wr_entry.registered = 1'b1;
        wr_en               = 1'b1;
      end
      FN_ALLOC: begin
        wr_entry.live_count  = cur.live_count + 32'd1;
        wr_entry.live_octets = cur.live_octets + size64;
        wr_entry.alloc_count = cur.alloc_count + 64'd1;
        wr_entry.alloc_bytes = cur.alloc_bytes + size64;
        wr_en                = 1'b1;
      end
      FN_FREE: begin
        if (cur.live_count == 32'd0) begin
          exec_word.status = STAT_UNDERFLOW;
        end else begin
          wr_entry.live_count = cur.live_count - 32'd1;
          // Live bytes saturate at zero rather than wrap.
          wr_entry.live_octets = (cur.live_octets >= size64) ?
                                 cur.live_octets - size64 : 64'd0;
          wr_entry.free_count = cur.free_count + 64'd1;
          wr_entry.free_bytes = cur.free_bytes + size64;
          wr_en               = 1'b1;
        end
      end
      FN_STATUS: begin
        exec_word.live_count      = cur.live_count;
        exec_word.live_byte_total = cur.live_octets;
        exec_word.alloc_count     = {32'd0, cur.alloc_count[31:0]};
        exec_word.free_count      = {32'd0, cur.free_count[31:0]};
      end
      default: wr_en = 1'b0;
    endcase
    if (slot_bad) begin
      exec_word        = '0;
      exec_word.status = STAT_BAD_SLOT;
      exec_word.last   = 1'b1;
      wr_en            = 1'b0;
    end
  end

  always_comb begin
    rec_word                  = '0;
    rec_word.status           = STAT_OK;
    rec_word.is_record        = 1'b1;
    rec_word.slot_out         = 3'(idx_r);
    rec_word.live_count       = cur.live_count;
    rec_word.live_byte_total  = cur.live_octets;
    rec_word.alloc_count      = cur.alloc_count;
    rec_word.free_count       = cur.free_count;
    rec_word.alloc_byte_total = cur.alloc_bytes;
    rec_word.free_byte_total  = cur.free_bytes;
    rec_word.ring_position    = head_r & RING_MASK;
    rec_word.last             = 1'b0;

    reply_word               = '0;
    reply_word.status        = STAT_OK;
    reply_word.ring_position = head_r;
    reply_word.last          = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = exec_word;
    end else if (cmd.rec_emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rec_word;
    end else if (cmd.reply_emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = reply_word;
    end

    head_nxt = cmd.rec_emit ? head_r + 32'd1 : head_r;

    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + SLOT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ring_en_r   <= 1'b0;
      head_r      <= '0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      if (cfg_valid) ring_en_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (cmd.load_req) req_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r <= '{default: '0};
    end else if (cmd.exec && wr_en) begin
      tbl_r[rd_idx] <= wr_entry;
    end
  end

endmodule

// ===== hdl/per_slot_alloc_counter_table.sv =====
// Per-slot allocation counter table: top level joining psac_ctrl and psac_dp.
// Depends on psac_pkg.
//
// Register, alloc, free and status requests pass through the accept state, in
// which the word is accepted, and the execute state, which reads the slot entry,
// updates it and loads the reply into the output register. With the ring
// enabled a snapshot passes the accept state, a walk over every slot, which
// reads the slot table through its single read port one entry per cycle unless
// a registered slot waits for the output register, and the closing reply. With
// the ring disabled a snapshot goes from the accept state to the reply. A record or
// reply waits in the output register while out_ready is low, which adds the
// stalled cycles to the request that needs the register next, and the next
// input word can be accepted while a final reply is still waiting there.
// Configuration writes are always taken.
module per_slot_alloc_counter_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psac_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output psac_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import psac_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  psac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hdl/psac_checker.sv =====
// Port-level checker for the per-slot allocation counter table, with its bind.
// Depends on psac_pkg.
module psac_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input psac_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input psac_pkg::out_word_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic                cfg_data
);
  import psac_pkg::*;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // A record is never the last word and is always ok.
  a_rec_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_record |-> !out_data.last && out_data.status == STAT_OK)
    else $error("malformed snapshot record");

  // While a record is pending the snapshot reply is still owed, so no input is taken.
  a_rec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_record |-> !in_ready)
    else $error("input taken during a snapshot");

  // A status or alloc request occupies the block for the cycle after acceptance.
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FN_STATUS || in_data.func == FN_ALLOC)
    |=> !in_ready)
    else $error("input ready too early after a slot request");

endmodule

bind per_slot_alloc_counter_table psac_checker u_psac_checker (.*);

// ===== tb/per_slot_alloc_counter_table_tb.sv =====
// Self-checking testbench for the per-slot allocation counter table.
// Drives requests, ring enable writes and output stalls, and predicts every reply
// and snapshot record with its own copy of the slot table. Depends on psac_pkg.
`timescale 1ns / 100ps

module per_slot_alloc_counter_table_tb;
  import psac_pkg::*;

  localparam int SETTLE_CYCLES = SLOTS + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] FN_UNUSED_LO = FN_SNAPSHOT + 3'd1;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  // Predicted slot table plus the queue of words the block still owes us.
  class counter_book;
    bit ring_on;
    bit [31:0] head;
    bit registered[SLOTS];
    bit [31:0] live_cnt[SLOTS];
    bit [63:0] live_octets[SLOTS];
    bit [63:0] alloc_cnt[SLOTS];
    bit [63:0] free_cnt[SLOTS];
    bit [63:0] alloc_bytes[SLOTS];
    bit [63:0] free_bytes[SLOTS];
    out_word_t expected_words[$];
    int mismatches;

    function int pending();
      return expected_words.size();
    endfunction

    function void set_ring(logic on);
      ring_on = on;
    endfunction

    function void take_request(in_word_t req);
      out_word_t rsp;
      out_word_t rec;
      int i;
      rsp = '0;
      rsp.last = 1'b1;
      if (req.func > FN_SNAPSHOT) return;
      if (req.func == FN_SNAPSHOT) begin
        if (ring_on) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!registered[s]) continue;
            rec = '0;
            rec.is_record = 1'b1;
            rec.slot_out = 3'(s);
            rec.live_count = live_cnt[s];
            rec.live_byte_total = live_octets[s];
            rec.alloc_count = alloc_cnt[s];
            rec.free_count = free_cnt[s];
            rec.alloc_byte_total = alloc_bytes[s];
            rec.free_byte_total = free_bytes[s];
            rec.ring_position = head % 32'(RING_ENTRIES);
            expected_words.push_back(rec);
            head++;
          end
        end
        rsp.ring_position = head;
        expected_words.push_back(rsp);
        return;
      end
      if (req.slot >= SLOTS) begin
        rsp.status = STAT_BAD_SLOT;
        expected_words.push_back(rsp);
        return;
      end
      i = int'(req.slot);
      case (req.func)
        FN_REGISTER: begin
          registered[i] = 1'b1;
          live_cnt[i] = '0;
          live_octets[i] = '0;
          alloc_cnt[i] = '0;
          free_cnt[i] = '0;
          alloc_bytes[i] = '0;
          free_bytes[i] = '0;
        end
        FN_ALLOC: begin
          live_cnt[i] += 1;
          live_octets[i] += {32'd0, req.size};
          alloc_cnt[i] += 1;
          alloc_bytes[i] += {32'd0, req.size};
        end
        FN_FREE: begin
          if (live_cnt[i] == 0) begin
            rsp.status = STAT_UNDERFLOW;
          end else begin
            live_cnt[i] -= 1;
            // Live bytes bottom out at zero rather than wrapping.
            if (live_octets[i] >= {32'd0, req.size}) live_octets[i] -= {32'd0, req.size};
            else live_octets[i] = '0;
            free_cnt[i] += 1;
            free_bytes[i] += {32'd0, req.size};
          end
        end
        default: begin
          rsp.live_count = live_cnt[i];
          rsp.live_byte_total = live_octets[i];
          rsp.alloc_count = {32'd0, alloc_cnt[i][31:0]};
          rsp.free_count = {32'd0, free_cnt[i][31:0]};
        end
      endcase
      expected_words.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void match_reply(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = expected_words.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("is_record", want.is_record, got.is_record);
      compare_field("slot_out", want.slot_out, got.slot_out);
      compare_field("live_count", want.live_count, got.live_count);
      compare_field("live_byte_total", want.live_byte_total, got.live_byte_total);
      compare_field("alloc_count", want.alloc_count, got.alloc_count);
      compare_field("free_count", want.free_count, got.free_count);
      compare_field("alloc_byte_total", want.alloc_byte_total, got.alloc_byte_total);
      compare_field("free_byte_total", want.free_byte_total, got.free_byte_total);
      compare_field("ring_position", want.ring_position, got.ring_position);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  bit idle_on = 1'b1;
  int quiet_cycles = 0;
  counter_book book;

  per_slot_alloc_counter_table DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !(idle_on && $urandom_range(99) < 6);
  end

  // All handshakes are observed here, so the model sees a request before any
  // word that could follow from it.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) book.set_ring(cfg_data);
      if (in_valid && in_ready) book.take_request(in_data);
      if (out_valid && out_ready) book.match_reply(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [2:0] f, input logic [7:0] s, input logic [31:0] z);
    in_word_t w;
    w.func = f;
    w.slot = s;
    w.size = z;
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender until the last expected word is back, then lets an
  // ignored request or a walk finish inside the block.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (book.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ring(input logic on);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= on;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic ring, input int count, input bit calm);
    in_word_t req;
    int counted;
    int pick;
    write_ring(ring);
    idle_on <= !calm;
    counted = 0;
    while (counted < count) begin
      pick = $urandom_range(99);
      if (pick < 4) req.func = FN_REGISTER;
      else if (pick < 40) req.func = FN_ALLOC;
      else if (pick < 68) req.func = FN_FREE;
      else if (pick < 84) req.func = FN_STATUS;
      else if (pick < 95) req.func = FN_SNAPSHOT;
      else req.func = 3'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
      if ($urandom_range(99) < 90) req.slot = 8'($urandom_range(SLOTS - 1));
      else req.slot = 8'($urandom_range(255, SLOTS));
      pick = $urandom_range(99);
      if (pick < 45) req.size = $urandom_range(32'h40000);
      else if (pick < 80) req.size = $urandom();
      else if (pick < 90) req.size = '0;
      else req.size = '1;
      send_request(req.func, req.slot, req.size);
      if (req.func <= FN_SNAPSHOT) begin
        counted++;
        if (counted == count / 2) wait_quiet();
      end
    end
  endtask

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    book = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_ring(1'b0);

    // With the ring off a snapshot gives only its reply; slot and size are ignored.
    send_request(FN_SNAPSHOT, 8'hFF, 32'hFFFF_FFFF);
    // An unregistered slot still counts.
    send_request(FN_STATUS, 8'd3, 32'd0);
    send_request(FN_FREE, 8'd3, 32'd5);
    send_request(FN_ALLOC, 8'd3, 32'hFFFF_FFFF);
    send_request(FN_ALLOC, 8'd3, 32'hFFFF_FFFF);
    send_request(FN_FREE, 8'd3, 32'd0);
    send_request(FN_STATUS, 8'd3, 32'd0);
    send_request(FN_REGISTER, 8'd0, 32'd0);
    send_request(FN_REGISTER, 8'd7, 32'hFFFF_FFFF);
    send_request(FN_REGISTER, 8'd3, 32'd0);
    send_request(FN_STATUS, 8'd3, 32'd0);
    send_request(FN_ALLOC, 8'd0, 32'd10);
    // Freeing more bytes than are live clamps the live bytes to zero.
    send_request(FN_FREE, 8'd0, 32'hFFFF_FFFF);
    send_request(FN_ALLOC, 8'd7, 32'd0);
    send_request(FN_STATUS, 8'd7, 32'd0);
    send_request(FN_REGISTER, 8'(SLOTS), 32'd0);
    send_request(FN_ALLOC, 8'hFF, 32'd1);
    send_request(FN_FREE, 8'(SLOTS), 32'd1);
    send_request(FN_STATUS, 8'h80, 32'd0);
    for (int f = FN_UNUSED_LO; f <= FN_UNUSED_HI; f++)
      send_request(3'(f), 8'd0, 32'd1);
    write_ring(1'b1);
    send_request(FN_SNAPSHOT, 8'd0, 32'd0);
    send_request(FN_SNAPSHOT, 8'hFF, 32'hFFFF_FFFF);

    run_phase(1'b1, 115, 1'b0);
    run_phase(1'b0, 115, 1'b1);
    run_phase(1'b1, 115, 1'b0);
    run_phase(1'b1, 115, 1'b0);
    wait_quiet();

    if (book.mismatches == 0 && book.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
